@@ rtl/core/drs_pkg.sv @@
`timescale 1ns / 1ps

package drs_pkg;

    localparam int DEF_MAX_ERRORS  = 1024;
    localparam int DEF_COUNT_WIDTH = 32;

    localparam int NUM_STATS = 20;
    localparam int DIV5_RECIP = 52429;
    localparam int DIV5_SHIFT = 18;
    localparam int SEL_PASSES = 16;

    localparam logic [15:0] LOW_LIMIT_RST  = 16'd320;
    localparam logic [15:0] MID_LIMIT_RST  = 16'd800;
    localparam logic [15:0] HIGH_LIMIT_RST = 16'd1600;

    localparam logic [1:0] CFG_LOW  = 2'd0;
    localparam logic [1:0] CFG_MID  = 2'd1;
    localparam logic [1:0] CFG_HIGH = 2'd2;

    typedef enum logic [2:0] {
        DS_ACC = 3'd1,
        DS_REC = 3'd2,
        DS_PRE = 3'd3,
        DS_FPR = 3'd4,
        DS_MAE = 3'd5,
        DS_MS  = 3'd6
    } t_div_sel;

    typedef enum logic [4:0] {
        ST_TOTAL    = 5'd0,
        ST_POS      = 5'd1,
        ST_NEG      = 5'd2,
        ST_ACC      = 5'd3,
        ST_TP       = 5'd4,
        ST_FP       = 5'd5,
        ST_ACC_RATE = 5'd6,
        ST_RECALL   = 5'd7,
        ST_PREC     = 5'd8,
        ST_FPR      = 5'd9,
        ST_N        = 5'd10,
        ST_MAE      = 5'd11,
        ST_RMSE     = 5'd12,
        ST_MAX      = 5'd13,
        ST_MEDIAN   = 5'd14,
        ST_P95      = 5'd15,
        ST_OUT_LOW  = 5'd16,
        ST_OUT_MID  = 5'd17,
        ST_OUT_HIGH = 5'd18,
        ST_OVERFLOW = 5'd19
    } t_stat_id;

    typedef struct packed {
        logic       frame;
        logic       rep_clr;
        logic       div_go;
        logic       div_latch;
        t_div_sel   div_sel;
        logic       sq_go;
        logic       rd_en;
        logic       rd_last;
        logic [3:0] pass;
        logic       emit;
        t_stat_id   emit_id;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic sq_done;
    } t_sts;

endpackage

@@ rtl/core/drs_div.sv @@
`timescale 1ns / 1ps

module drs_div #(
    parameter int NW   = 48,
    parameter int DENW = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_go,
    input  logic [NW-1:0]   i_num,
    input  logic [DENW-1:0] i_den,
    output logic            o_done,
    output logic [NW-1:0]   o_quot
);

    localparam int CNTW = $clog2(NW + 1);

    logic            r_busy;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic [NW-1:0]   r_num;
    logic [DENW-1:0] r_den;
    logic [DENW-1:0] r_rem;
    logic [DENW:0]   n_rem_s;
    logic [DENW:0]   n_diff;
    logic            n_ge;

    always_comb begin
        n_rem_s = {r_rem, r_num[NW-1]};
        n_ge    = n_rem_s >= {1'b0, r_den};
        n_diff  = n_rem_s - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNTW'(1);
                if (r_cnt == CNTW'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[NW-2:0], n_ge};
            r_rem <= n_ge ? n_diff[DENW-1:0] : n_rem_s[DENW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

@@ rtl/core/drs_sqrt.sv @@
`timescale 1ns / 1ps

module drs_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_go,
    input  logic [31:0] i_x,
    output logic        o_done,
    output logic [15:0] o_root
);

    logic        r_busy;
    logic        r_done;
    logic [3:0]  r_step;
    logic [31:0] r_x;
    logic [31:0] r_r;
    logic [31:0] n_bit;
    logic [31:0] n_trial;

    always_comb begin
        n_bit   = 32'd1 << {r_step, 1'b0};
        n_trial = r_r + n_bit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_step <= 4'd15;
            end else if (r_busy) begin
                r_step <= r_step - 4'd1;
                if (r_step == 4'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_x <= i_x;
            r_r <= '0;
        end else if (r_busy) begin
            if (r_x >= n_trial) begin
                r_x <= r_x - n_trial;
                r_r <= (r_r >> 1) + n_bit;
            end else begin
                r_r <= r_r >> 1;
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_r[15:0];

endmodule

@@ rtl/core/drs_dp.sv @@
`timescale 1ns / 1ps

module drs_dp #(
    parameter int MAX_ERRORS  = drs_pkg::DEF_MAX_ERRORS,
    parameter int COUNT_WIDTH = drs_pkg::DEF_COUNT_WIDTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  drs_pkg::t_cmd                        i_cmd,
    input  logic [$clog2(MAX_ERRORS)-1:0]        i_rd_addr,
    output drs_pkg::t_sts                        o_sts,
    output logic [$clog2(MAX_ERRORS+1)-1:0]      o_fill,
    input  logic                                 i_cfg_we,
    input  logic [1:0]                           i_cfg_idx,
    input  logic [15:0]                          i_cfg_data,
    input  logic                                 i_truth_present,
    input  logic                                 i_accepted,
    input  logic                                 i_error_valid,
    input  logic [15:0]                          i_error_px,
    output logic                                 o_valid,
    output logic [4:0]                           o_stat_id,
    output logic [31:0]                          o_stat_value,
    output logic                                 o_last
);

    localparam int AW   = $clog2(MAX_ERRORS + 1);
    localparam int ADW  = $clog2(MAX_ERRORS);
    localparam int CW   = COUNT_WIDTH;
    localparam int XW   = (CW > 32) ? CW : 32;
    localparam int SW   = 16 + AW;
    localparam int QW   = 32 + AW;
    localparam int NW   = (CW + 16 > QW) ? CW + 16 : QW;
    localparam int DENW = (CW > AW) ? CW : AW;
    localparam int PW   = AW + 16;

    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] c);
        sat_inc = (c == {CW{1'b1}}) ? c : c + CW'(1);
    endfunction

    function automatic logic [31:0] clip32(input logic [CW-1:0] c);
        logic [XW-1:0] x;
        x = XW'(c);
        clip32 = (x > XW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : x[31:0];
    endfunction

    logic [15:0]   r_lim_low;
    logic [15:0]   r_lim_mid;
    logic [15:0]   r_lim_high;
    logic [CW-1:0] r_total;
    logic [CW-1:0] r_pos;
    logic [CW-1:0] r_neg;
    logic [CW-1:0] r_acc;
    logic [CW-1:0] r_tp;
    logic [CW-1:0] r_fp;
    logic [AW-1:0] r_fill;
    logic          r_ovf;
    logic [15:0]   r_mem [MAX_ERRORS];

    logic          r_rd_vld;
    logic          r_rd_last;
    logic [3:0]    r_rd_pass;
    logic [15:0]   r_rd_data;

    logic [SW-1:0] r_sum;
    logic [QW-1:0] r_sumsq;
    logic [15:0]   r_max;
    logic [AW-1:0] r_out_low;
    logic [AW-1:0] r_out_mid;
    logic [AW-1:0] r_out_high;
    logic [15:0]   r_ans [3];
    logic [AW-1:0] r_cnt [3];

    logic [16:0]   r_ratio_acc;
    logic [16:0]   r_ratio_rec;
    logic [16:0]   r_ratio_pre;
    logic [16:0]   r_ratio_fpr;
    logic [15:0]   r_mae;
    logic [31:0]   r_ms;
    logic [15:0]   r_rmse;

    logic          r_valid;
    logic [4:0]    r_id;
    logic [31:0]   r_val;
    logic          r_last;

    logic [NW-1:0]   n_num;
    logic [DENW-1:0] n_den;
    logic [NW-1:0]   n_quot;
    logic            n_div_done;
    logic            n_sq_done;
    logic [15:0]     n_root;
    logic [AW-1:0]   n_half;
    logic [AW-1:0]   n_k [3];
    logic [16:0]     n_bitv;
    logic [AW-1:0]   n_cnt [3];
    logic            n_store;
    logic [16:0]     n_ratio;
    logic [PW-1:0]   n_prod;
    logic [AW-1:0]   n_div20;
    logic [AW-1:0]   n_pidx;
    logic [15:0]     n_median;
    logic [31:0]     n_val;

    drs_div #(.NW(NW), .DENW(DENW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_cmd.div_go),
        .i_num   (n_num),
        .i_den   (n_den),
        .o_done  (n_div_done),
        .o_quot  (n_quot)
    );

    drs_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_cmd.sq_go),
        .i_x     (r_ms),
        .o_done  (n_sq_done),
        .o_root  (n_root)
    );

    always_comb begin
        n_num = '0;
        n_den = '0;
        case (i_cmd.div_sel)
            drs_pkg::DS_ACC: begin
                n_num = NW'({r_acc, 16'h0000});
                n_den = DENW'(r_total);
            end
            drs_pkg::DS_REC: begin
                n_num = NW'({r_tp, 16'h0000});
                n_den = DENW'(r_pos);
            end
            drs_pkg::DS_PRE: begin
                n_num = NW'({r_tp, 16'h0000});
                n_den = DENW'(r_acc);
            end
            drs_pkg::DS_FPR: begin
                n_num = NW'({r_fp, 16'h0000});
                n_den = DENW'(r_neg);
            end
            drs_pkg::DS_MAE: begin
                n_num = NW'(r_sum);
                n_den = DENW'(r_fill);
            end
            drs_pkg::DS_MS: begin
                n_num = NW'(r_sumsq);
                n_den = DENW'(r_fill);
            end
            default: begin
                n_num = '0;
                n_den = '0;
            end
        endcase
    end

    // The nearest-rank p95 index is n - 1 - floor(n / 20); the division by five of n / 4
    // is a reciprocal multiplication that is exact for every store of fewer than 2^20 entries.
    always_comb begin
        n_ratio = (n_den == '0) ? 17'd0 :
                  (n_quot > NW'(65536)) ? 17'd65536 : n_quot[16:0];
        n_prod  = PW'(r_fill >> 2) * PW'(drs_pkg::DIV5_RECIP);
        n_div20 = AW'(n_prod >> drs_pkg::DIV5_SHIFT);
        n_pidx  = r_fill - AW'(1) - n_div20;
        n_half  = r_fill >> 1;
        n_k[0]  = r_fill[0] ? n_half : n_half - AW'(1);
        n_k[1]  = n_half;
        n_k[2]  = n_pidx;
        n_bitv  = 17'd1 << (4'd15 - r_rd_pass);
        for (int j = 0; j < 3; j++) begin
            n_cnt[j] = r_cnt[j] + AW'({1'b0, r_rd_data} < ({1'b0, r_ans[j]} + n_bitv));
        end
        n_store = i_cmd.frame && i_truth_present && i_accepted && i_error_valid;
        n_median = r_fill[0] ? r_ans[0] : 16'(({1'b0, r_ans[0]} + {1'b0, r_ans[1]}) >> 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim_low  <= drs_pkg::LOW_LIMIT_RST;
            r_lim_mid  <= drs_pkg::MID_LIMIT_RST;
            r_lim_high <= drs_pkg::HIGH_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                drs_pkg::CFG_LOW:  r_lim_low  <= i_cfg_data;
                drs_pkg::CFG_MID:  r_lim_mid  <= i_cfg_data;
                drs_pkg::CFG_HIGH: r_lim_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_pos   <= '0;
            r_neg   <= '0;
            r_acc   <= '0;
            r_tp    <= '0;
            r_fp    <= '0;
            r_fill  <= '0;
            r_ovf   <= 1'b0;
        end else if (i_cmd.frame) begin
            r_total <= sat_inc(r_total);
            if (i_truth_present) begin
                r_pos <= sat_inc(r_pos);
            end else begin
                r_neg <= sat_inc(r_neg);
            end
            if (i_accepted) begin
                r_acc <= sat_inc(r_acc);
                if (i_truth_present) begin
                    r_tp <= sat_inc(r_tp);
                end else begin
                    r_fp <= sat_inc(r_fp);
                end
            end
            if (n_store) begin
                if (r_fill < AW'(MAX_ERRORS)) begin
                    r_fill <= r_fill + AW'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_store && (r_fill < AW'(MAX_ERRORS))) begin
            r_mem[r_fill[ADW-1:0]] <= i_error_px;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_last <= i_cmd.rd_last;
        r_rd_pass <= i_cmd.pass;
        if (i_cmd.rep_clr) begin
            r_sum      <= '0;
            r_sumsq    <= '0;
            r_max      <= '0;
            r_out_low  <= '0;
            r_out_mid  <= '0;
            r_out_high <= '0;
            for (int j = 0; j < 3; j++) begin
                r_ans[j] <= '0;
                r_cnt[j] <= '0;
            end
        end else if (r_rd_vld) begin
            if (r_rd_pass == 4'd0) begin
                r_sum   <= r_sum + SW'(r_rd_data);
                r_sumsq <= r_sumsq + QW'(32'(r_rd_data) * 32'(r_rd_data));
                if (r_rd_data > r_max) begin
                    r_max <= r_rd_data;
                end
                r_out_low  <= r_out_low + AW'(r_rd_data > r_lim_low);
                r_out_mid  <= r_out_mid + AW'(r_rd_data > r_lim_mid);
                r_out_high <= r_out_high + AW'(r_rd_data > r_lim_high);
            end
            for (int j = 0; j < 3; j++) begin
                if (r_rd_last) begin
                    r_cnt[j] <= '0;
                    if (n_cnt[j] <= n_k[j]) begin
                        r_ans[j] <= r_ans[j] + n_bitv[15:0];
                    end
                end else begin
                    r_cnt[j] <= n_cnt[j];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_latch) begin
            case (i_cmd.div_sel)
                drs_pkg::DS_ACC: r_ratio_acc <= n_ratio;
                drs_pkg::DS_REC: r_ratio_rec <= n_ratio;
                drs_pkg::DS_PRE: r_ratio_pre <= n_ratio;
                drs_pkg::DS_FPR: r_ratio_fpr <= n_ratio;
                drs_pkg::DS_MAE: r_mae <= (n_den == '0) ? 16'd0 : n_quot[15:0];
                drs_pkg::DS_MS:  r_ms  <= (n_den == '0) ? 32'd0 : n_quot[31:0];
                default: ;
            endcase
        end
        if (n_sq_done) begin
            r_rmse <= n_root;
        end
    end

    always_comb begin
        case (i_cmd.emit_id)
            drs_pkg::ST_TOTAL:    n_val = clip32(r_total);
            drs_pkg::ST_POS:      n_val = clip32(r_pos);
            drs_pkg::ST_NEG:      n_val = clip32(r_neg);
            drs_pkg::ST_ACC:      n_val = clip32(r_acc);
            drs_pkg::ST_TP:       n_val = clip32(r_tp);
            drs_pkg::ST_FP:       n_val = clip32(r_fp);
            drs_pkg::ST_ACC_RATE: n_val = 32'(r_ratio_acc);
            drs_pkg::ST_RECALL:   n_val = 32'(r_ratio_rec);
            drs_pkg::ST_PREC:     n_val = 32'(r_ratio_pre);
            drs_pkg::ST_FPR:      n_val = 32'(r_ratio_fpr);
            drs_pkg::ST_N:        n_val = 32'(r_fill);
            drs_pkg::ST_MAE:      n_val = 32'(r_mae);
            drs_pkg::ST_RMSE:     n_val = 32'(r_rmse);
            drs_pkg::ST_MAX:      n_val = 32'(r_max);
            drs_pkg::ST_MEDIAN:   n_val = 32'(n_median);
            drs_pkg::ST_P95:      n_val = 32'(r_ans[2]);
            drs_pkg::ST_OUT_LOW:  n_val = 32'(r_out_low);
            drs_pkg::ST_OUT_MID:  n_val = 32'(r_out_mid);
            drs_pkg::ST_OUT_HIGH: n_val = 32'(r_out_high);
            drs_pkg::ST_OVERFLOW: n_val = 32'(r_ovf);
            default:              n_val = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id   <= i_cmd.emit_id;
        r_val  <= n_val;
        r_last <= (i_cmd.emit_id == drs_pkg::ST_OVERFLOW);
    end

    assign o_sts.div_done = n_div_done;
    assign o_sts.sq_done  = n_sq_done;
    assign o_fill         = r_fill;
    assign o_valid        = r_valid;
    assign o_stat_id      = r_id;
    assign o_stat_value   = r_val;
    assign o_last         = r_last;

endmodule

@@ rtl/core/drs_ctrl.sv @@
`timescale 1ns / 1ps

module drs_ctrl #(
    parameter int MAX_ERRORS = drs_pkg::DEF_MAX_ERRORS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    input  logic                                i_mode,
    output logic                                busy,
    input  drs_pkg::t_sts                       i_sts,
    input  logic [$clog2(MAX_ERRORS+1)-1:0]     i_fill,
    output drs_pkg::t_cmd                       o_cmd,
    output logic [$clog2(MAX_ERRORS)-1:0]       o_rd_addr
);

    localparam int AW  = $clog2(MAX_ERRORS + 1);
    localparam int ADW = $clog2(MAX_ERRORS);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_DGO    = 8'b0000_0010,
        S_DWAIT  = 8'b0000_0100,
        S_SCAN   = 8'b0000_1000,
        S_DRAIN  = 8'b0001_0000,
        S_SQGO   = 8'b0010_0000,
        S_SQWAIT = 8'b0100_0000,
        S_EMIT   = 8'b1000_0000
    } t_state;

    t_state             r_state;
    t_state             n_state;
    drs_pkg::t_div_sel  r_sel;
    drs_pkg::t_div_sel  n_sel;
    logic [3:0]         r_pass;
    logic [3:0]         n_pass;
    logic [ADW-1:0]     r_addr;
    logic [ADW-1:0]     n_addr;
    drs_pkg::t_stat_id  r_id;
    drs_pkg::t_stat_id  n_id;
    logic               n_scan_last;

    assign n_scan_last = (r_addr == ADW'(i_fill - AW'(1)));

    always_comb begin
        n_state = r_state;
        n_sel   = r_sel;
        n_pass  = r_pass;
        n_addr  = r_addr;
        n_id    = r_id;
        o_cmd   = '0;
        o_cmd.div_sel = r_sel;
        o_cmd.pass    = r_pass;
        o_cmd.emit_id = r_id;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_mode) begin
                        o_cmd.rep_clr = 1'b1;
                        n_sel   = drs_pkg::DS_ACC;
                        n_state = S_DGO;
                    end else begin
                        o_cmd.frame = 1'b1;
                    end
                end
            end
            S_DGO: begin
                o_cmd.div_go = 1'b1;
                n_state = S_DWAIT;
            end
            S_DWAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.div_latch = 1'b1;
                    n_state = S_DGO;
                    case (r_sel)
                        drs_pkg::DS_ACC: n_sel = drs_pkg::DS_REC;
                        drs_pkg::DS_REC: n_sel = drs_pkg::DS_PRE;
                        drs_pkg::DS_PRE: n_sel = drs_pkg::DS_FPR;
                        drs_pkg::DS_FPR: begin
                            n_sel = drs_pkg::DS_MAE;
                            if (i_fill != '0) begin
                                n_state = S_SCAN;
                                n_pass  = '0;
                                n_addr  = '0;
                            end
                        end
                        drs_pkg::DS_MAE: n_sel = drs_pkg::DS_MS;
                        default: n_state = S_SQGO;
                    endcase
                end
            end
            S_SCAN: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_last = n_scan_last;
                if (n_scan_last) begin
                    n_addr = '0;
                    if (r_pass == 4'(drs_pkg::SEL_PASSES - 1)) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_pass = r_pass + 4'd1;
                    end
                end else begin
                    n_addr = r_addr + ADW'(1);
                end
            end
            S_DRAIN: begin
                n_state = S_DGO;
            end
            S_SQGO: begin
                o_cmd.sq_go = 1'b1;
                n_state = S_SQWAIT;
            end
            S_SQWAIT: begin
                if (i_sts.sq_done) begin
                    n_id    = drs_pkg::ST_TOTAL;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                if (r_id == drs_pkg::ST_OVERFLOW) begin
                    n_state = S_IDLE;
                end else begin
                    n_id = drs_pkg::t_stat_id'(r_id + 5'd1);
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sel   <= drs_pkg::DS_ACC;
            r_pass  <= '0;
            r_addr  <= '0;
            r_id    <= drs_pkg::ST_TOTAL;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
            r_pass  <= n_pass;
            r_addr  <= n_addr;
            r_id    <= n_id;
        end
    end

    assign busy      = (r_state != S_IDLE);
    assign o_rd_addr = r_addr;

endmodule

@@ rtl/core/detection_rate_and_error_statistics_core.sv @@
`timescale 1ns / 1ps
// Frame and localisation-error statistics core.
// A transaction is accepted on a rising edge with start high and busy low.
// With i_mode low it is a frame: the six saturating counters update and, for a true
// positive carrying an error, the error is written to the error store; busy stays low,
// so one frame can be taken in every cycle.
// With i_mode high it requests a report: busy rises and, once the statistics are
// ready, twenty results are shown on consecutive cycles, each marked by o_valid for
// one cycle, o_last on the final one. The receiver cannot stall the results.
// Before the first result, the shared bit-serial divider forms the four ratios, then
// sixteen bitwise selection passes over the error store find the median and the p95
// (no passes when the store is empty), the divider forms the mean error and the mean
// square, and a bit-serial square root gives the RMSE. The divider width NW is the
// larger of COUNT_WIDTH + 16 and 32 + clog2(MAX_ERRORS + 1). Busy falls while the last
// result is shown, so the next transaction can be taken then. The user must write the
// outlier limits via i_cfg_we, i_cfg_idx and i_cfg_data while idle; it is not enforced.
// Synchronous reset clears the six frame counters, the store fill and the overflow flag and
// restores the default limits; the store contents are not cleared.

module detection_rate_and_error_statistics_core #(
    parameter int MAX_ERRORS  = drs_pkg::DEF_MAX_ERRORS,
    parameter int COUNT_WIDTH = drs_pkg::DEF_COUNT_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_mode,
    input  logic        i_truth_present,
    input  logic        i_accepted,
    input  logic        i_error_valid,
    input  logic [15:0] i_error_px,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    output logic        o_valid,
    output logic [4:0]  o_stat_id,
    output logic [31:0] o_stat_value,
    output logic        o_last
);

    drs_pkg::t_cmd                    cmd;
    drs_pkg::t_sts                    sts;
    logic [$clog2(MAX_ERRORS+1)-1:0]  fill;
    logic [$clog2(MAX_ERRORS)-1:0]    rd_addr;

    drs_ctrl #(.MAX_ERRORS(MAX_ERRORS)) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_mode    (i_mode),
        .busy      (busy),
        .i_sts     (sts),
        .i_fill    (fill),
        .o_cmd     (cmd),
        .o_rd_addr (rd_addr)
    );

    drs_dp #(.MAX_ERRORS(MAX_ERRORS), .COUNT_WIDTH(COUNT_WIDTH)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_rd_addr       (rd_addr),
        .o_sts           (sts),
        .o_fill          (fill),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_truth_present (i_truth_present),
        .i_accepted      (i_accepted),
        .i_error_valid   (i_error_valid),
        .i_error_px      (i_error_px),
        .o_valid         (o_valid),
        .o_stat_id       (o_stat_id),
        .o_stat_value    (o_stat_value),
        .o_last          (o_last)
    );

endmodule

@@ rtl/core/drs_chk.sv @@
`timescale 1ns / 1ps

module drs_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       i_mode,
    input logic       o_valid,
    input logic [4:0] o_stat_id,
    input logic       o_last
);

    a_last_is_final_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> o_stat_id == drs_pkg::ST_OVERFLOW)
        else $error("last flag not on the final statistic");

    a_burst_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |=> o_valid && (o_stat_id == $past(o_stat_id) + 5'd1))
        else $error("report burst broken or out of order");

    a_report_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_mode |=> busy)
        else $error("report request did not raise busy");

    a_no_result_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> busy)
        else $error("result shown while idle");

endmodule

bind detection_rate_and_error_statistics_core drs_chk u_drs_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .start     (start),
    .busy      (busy),
    .i_mode    (i_mode),
    .o_valid   (o_valid),
    .o_stat_id (o_stat_id),
    .o_last    (o_last)
);

@@ dv/tb_detection_rate_and_error_statistics_core.sv @@
`timescale 1ns / 1ps

class stats_scoreboard;
    logic [15:0] lim_low;
    logic [15:0] lim_mid;
    logic [15:0] lim_high;
    logic [32:0] frames;
    logic [32:0] positives;
    logic [32:0] negatives;
    logic [32:0] accepts;
    logic [32:0] true_pos;
    logic [32:0] false_pos;
    logic [15:0] errors[$];
    bit          overflowed;
    logic [31:0] pending_value[$];
    logic [4:0]  pending_id[$];
    logic        pending_last[$];
    int          mismatches;

    function new();
        lim_low = drs_pkg::LOW_LIMIT_RST;
        lim_mid = drs_pkg::MID_LIMIT_RST;
        lim_high = drs_pkg::HIGH_LIMIT_RST;
        frames = 0;
        positives = 0;
        negatives = 0;
        accepts = 0;
        true_pos = 0;
        false_pos = 0;
        overflowed = 0;
        mismatches = 0;
    endfunction

    function void set_limit(logic [1:0] idx, logic [15:0] val);
        if (idx == drs_pkg::CFG_LOW) lim_low = val;
        else if (idx == drs_pkg::CFG_MID) lim_mid = val;
        else if (idx == drs_pkg::CFG_HIGH) lim_high = val;
    endfunction

    function logic [32:0] bump(logic [32:0] c);
        return (c >= 33'hFFFF_FFFF) ? 33'hFFFF_FFFF : c + 33'd1;
    endfunction

    function logic [31:0] ratio(logic [32:0] num, logic [32:0] den);
        logic [63:0] q;
        if (den == 0) return 32'd0;
        q = {15'd0, num, 16'd0} / den;
        return (q > 65536) ? 32'd65536 : q[31:0];
    endfunction

    function logic [63:0] int_sqrt(logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function void push(logic [4:0] id, logic [31:0] val);
        pending_id.insert(pending_id.size(), id);
        pending_value.insert(pending_value.size(), val);
        pending_last.insert(pending_last.size(), id == drs_pkg::ST_OVERFLOW);
    endfunction

    function void note_item(logic md, logic tr, logic ac, logic ev, logic [15:0] px);
        logic [15:0] srt[$];
        logic [63:0] sum;
        logic [63:0] sumsq;
        int          n;
        int          lo;
        int          mi;
        int          hi;
        int          idx;
        if (!md) begin
            frames = bump(frames);
            if (tr) positives = bump(positives);
            else negatives = bump(negatives);
            if (ac) begin
                accepts = bump(accepts);
                if (tr) begin
                    true_pos = bump(true_pos);
                    if (ev) begin
                        if (errors.size() < drs_pkg::DEF_MAX_ERRORS)
                            errors.insert(errors.size(), px);
                        else overflowed = 1;
                    end
                end else begin
                    false_pos = bump(false_pos);
                end
            end
            return;
        end
        push(drs_pkg::ST_TOTAL, frames[31:0]);
        push(drs_pkg::ST_POS, positives[31:0]);
        push(drs_pkg::ST_NEG, negatives[31:0]);
        push(drs_pkg::ST_ACC, accepts[31:0]);
        push(drs_pkg::ST_TP, true_pos[31:0]);
        push(drs_pkg::ST_FP, false_pos[31:0]);
        push(drs_pkg::ST_ACC_RATE, ratio(accepts, frames));
        push(drs_pkg::ST_RECALL, ratio(true_pos, positives));
        push(drs_pkg::ST_PREC, ratio(true_pos, accepts));
        push(drs_pkg::ST_FPR, ratio(false_pos, negatives));
        n = errors.size();
        srt = errors;
        srt.sort();
        sum = 0;
        sumsq = 0;
        lo = 0;
        mi = 0;
        hi = 0;
        foreach (srt[i]) begin
            sum += srt[i];
            sumsq += 64'(srt[i]) * srt[i];
            if (srt[i] > lim_low) lo++;
            if (srt[i] > lim_mid) mi++;
            if (srt[i] > lim_high) hi++;
        end
        if (n == 0) begin
            for (int k = drs_pkg::ST_N; k <= drs_pkg::ST_OUT_HIGH; k++) push(5'(k), 32'd0);
        end else begin
            idx = (n * 19 + 19) / 20 - 1;
            if (idx > n - 1) idx = n - 1;
            push(drs_pkg::ST_N, 32'(n));
            push(drs_pkg::ST_MAE, 32'(sum / n));
            push(drs_pkg::ST_RMSE, 32'(int_sqrt(sumsq / n)));
            push(drs_pkg::ST_MAX, 32'(srt[n-1]));
            if (n % 2) push(drs_pkg::ST_MEDIAN, 32'(srt[n/2]));
            else push(drs_pkg::ST_MEDIAN, (32'(srt[n/2-1]) + 32'(srt[n/2])) >> 1);
            push(drs_pkg::ST_P95, 32'(srt[idx]));
            push(drs_pkg::ST_OUT_LOW, 32'(lo));
            push(drs_pkg::ST_OUT_MID, 32'(mi));
            push(drs_pkg::ST_OUT_HIGH, 32'(hi));
        end
        push(drs_pkg::ST_OVERFLOW, 32'(overflowed));
    endfunction

    task flag(string what);
        $display("mismatch: %s", what);
        mismatches++;
    endtask

    task check_result(logic [4:0] id, logic [31:0] val, logic lst);
        if (pending_id.size() == 0) begin
            flag($sformatf("unexpected result id %0d value %0d", id, val));
            return;
        end
        if (id !== pending_id[0])
            flag($sformatf("stat_id %0d, expected %0d", id, pending_id[0]));
        if (val !== pending_value[0])
            flag($sformatf("stat %0d value %0d, expected %0d", pending_id[0], val,
                           pending_value[0]));
        if (lst !== pending_last[0])
            flag($sformatf("stat %0d last %0b", pending_id[0], lst));
        void'(pending_id.pop_front());
        void'(pending_value.pop_front());
        void'(pending_last.pop_front());
    endtask
endclass

module tb_detection_rate_and_error_statistics_core;

    localparam int WATCHDOG_LIMIT = 200000;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        start = 0;
    logic        busy;
    logic        i_mode = 0;
    logic        i_truth_present = 0;
    logic        i_accepted = 0;
    logic        i_error_valid = 0;
    logic [15:0] i_error_px = 0;
    logic        i_cfg_we = 0;
    logic [1:0]  i_cfg_idx = 0;
    logic [15:0] i_cfg_data = 0;
    logic        o_valid;
    logic [4:0]  o_stat_id;
    logic [31:0] o_stat_value;
    logic        o_last;

    stats_scoreboard board = new();
    int  idle_cycles = 0;
    bit  no_gaps = 0;
    bit  done = 0;

    detection_rate_and_error_statistics_core dut (.*);

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) board.check_result(o_stat_id, o_stat_value, o_last);
        if (i_rst_n && ((start && !busy) || o_valid)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT && !done) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Start is left high after a transaction so that frames can follow back to back;
    // a random gap before the next send, or wait_drained, lowers it.
    task automatic send(logic md, logic tr, logic ac, logic ev, logic [15:0] px);
        int gap;
        if (!no_gaps && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 17);
            start <= 0;
            repeat (gap) @(negedge i_clk);
        end
        start <= 1;
        i_mode <= md;
        i_truth_present <= tr;
        i_accepted <= ac;
        i_error_valid <= ev;
        i_error_px <= px;
        while (busy) @(negedge i_clk);
        @(negedge i_clk);
        board.note_item(md, tr, ac, ev, px);
    endtask

    task automatic report();
        send(1, 1'($urandom), 1'($urandom), 1'($urandom), 16'($urandom));
        wait_drained();
    endtask

    task automatic wait_drained();
        start <= 0;
        while (board.pending_id.size() != 0 || busy) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_limit(logic [1:0] idx, logic [15:0] val);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 0;
        board.set_limit(idx, val);
    endtask

    task automatic random_frame();
        logic [15:0] px;
        case ($urandom_range(0, 3))
            0: px = 16'($urandom_range(0, 400));
            1: px = 16'($urandom_range(300, 2000));
            2: px = 16'($urandom);
            default: px = {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000};
        endcase
        send(0, $urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0,
             $urandom_range(0, 4) != 0, px);
    endtask

    initial begin
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        report();
        send(0, 1, 1, 1, 16'h0000);
        report();
        send(0, 1, 1, 1, 16'hFFFF);
        send(0, 0, 1, 1, 16'h1234);
        send(0, 1, 0, 1, 16'h4321);
        send(0, 0, 0, 0, 16'h0000);
        send(0, 1, 1, 0, 16'h5555);
        send(0, 1, 1, 1, 16'hAAAA);
        send(0, 1, 1, 1, 16'd320);
        send(0, 1, 1, 1, 16'd321);
        send(0, 1, 1, 1, 16'd800);
        send(0, 1, 1, 1, 16'd1601);
        report();

        write_limit(drs_pkg::CFG_LOW, 16'd0);
        write_limit(drs_pkg::CFG_MID, 16'hFFFF);
        write_limit(drs_pkg::CFG_HIGH, 16'h5555);
        for (int i = 0; i < 90; i++) random_frame();
        report();
        write_limit(drs_pkg::CFG_LOW, 16'hFFFF);
        write_limit(drs_pkg::CFG_MID, 16'd0);
        write_limit(drs_pkg::CFG_HIGH, 16'hAAAA);
        for (int i = 0; i < 80; i++) random_frame();
        report();
        write_limit(drs_pkg::CFG_LOW, 16'($urandom));
        write_limit(drs_pkg::CFG_MID, 16'($urandom));
        write_limit(drs_pkg::CFG_HIGH, 16'd0);
        no_gaps = 1;
        for (int i = 0; i < 50; i++) random_frame();
        report();

        send(0, 1, 1, 1, 16'($urandom));
        report();
        write_limit(drs_pkg::CFG_HIGH, 16'hFFFF);
        report();

        wait_drained();
        done = 1;
        if (board.mismatches == 0 && board.pending_id.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

@@ sim.f @@
rtl/core/drs_pkg.sv
rtl/core/drs_div.sv
rtl/core/drs_sqrt.sv
rtl/core/drs_dp.sv
rtl/core/drs_ctrl.sv
rtl/core/detection_rate_and_error_statistics_core.sv
rtl/core/drs_chk.sv
dv/tb_detection_rate_and_error_statistics_core.sv
